// ===== hdl/rth_pkg.sv =====
// Shared constants for the RGB to HSV converter.
`timescale 1ns / 1ps

package rth_pkg;

    // Default widths
    localparam int RTH_CHANNEL_BITS   = 8;
    localparam int RTH_HUE_FRAC_BITS  = 8;

    // Bit positions of the flags in the sideband word that rides along the divider row;
    // brightness sits above the flags
    localparam int RTH_SIDE_HUE_ZERO  = 0;
    localparam int RTH_SIDE_SAT_ZERO  = 1;
    localparam int RTH_SIDE_FLAGS     = 2;

    // Lane numbers in the divider row
    localparam int RTH_LANE_HUE       = 0;
    localparam int RTH_LANE_SAT       = 1;
    localparam int RTH_LANES          = 2;

endpackage

// ===== hdl/rth_front.sv =====
// Front end: max/min search, delta and the two dividends for the divider row.
`timescale 1ns / 1ps

module rth_front #(
    parameter int CHANNEL_BITS      = rth_pkg::RTH_CHANNEL_BITS,
    parameter int HUE_FRACTION_BITS = rth_pkg::RTH_HUE_FRAC_BITS,
    parameter int QUO_BITS          = rth_pkg::RTH_HUE_FRAC_BITS + 3
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         in_valid,
    output logic                                         in_ready,
    input  logic [CHANNEL_BITS-1:0]                      red,
    input  logic [CHANNEL_BITS-1:0]                      green,
    input  logic [CHANNEL_BITS-1:0]                      blue,
    output logic                                         out_valid,
    input  logic                                         out_ready,
    output logic [rth_pkg::RTH_LANES-1:0][CHANNEL_BITS-1:0] out_rem,
    output logic [rth_pkg::RTH_LANES-1:0][CHANNEL_BITS-1:0] out_dvr,
    output logic [rth_pkg::RTH_LANES-1:0][QUO_BITS-1:0]     out_dvd,
    output logic [CHANNEL_BITS+rth_pkg::RTH_SIDE_FLAGS-1:0] out_side
);
    import rth_pkg::*;

    localparam int CB  = CHANNEL_BITS;
    localparam int NW  = QUO_BITS + CHANNEL_BITS;
    localparam int NUW = CHANNEL_BITS + 3;

    // Which channel is largest, and for red whether hue wraps below zero
    typedef enum logic [1:0] {
        MAX_RED_UP,
        MAX_RED_WRAP,
        MAX_GREEN,
        MAX_BLUE
    } rth_maxsel_t;

    // Stage A registers
    logic              a_valid_reg;
    logic [CB-1:0]     a_red_reg, a_green_reg, a_blue_reg;
    logic [CB-1:0]     a_max_reg, a_min_reg;
    rth_maxsel_t       a_sel_reg;
    logic              a_ready;

    // Stage B registers
    logic              b_valid_reg;
    logic              b_ready;
    logic [RTH_LANES-1:0][CB-1:0]       b_rem_reg, b_dvr_reg;
    logic [RTH_LANES-1:0][QUO_BITS-1:0] b_dvd_reg;
    logic [CB+RTH_SIDE_FLAGS-1:0]       b_side_reg;

    logic [CB-1:0]     a_max_next, a_min_next;
    rth_maxsel_t       a_sel_next;

    logic [CB-1:0]     delta;
    logic [NUW-1:0]    base, x_term, y_term, hue_num;
    logic [NW-1:0]     hue_n, sat_n;

    // Ready chain: a stage takes a beat when empty or when it empties this cycle
    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // Largest, smallest and winning channel; red beats green beats blue on ties
    always_comb begin
        a_max_next = red;
        a_min_next = red;
        if (green > a_max_next) a_max_next = green;
        if (blue > a_max_next)  a_max_next = blue;
        if (green < a_min_next) a_min_next = green;
        if (blue < a_min_next)  a_min_next = blue;
        if (red >= green && red >= blue) begin
            a_sel_next = (green >= blue) ? MAX_RED_UP : MAX_RED_WRAP;
        end else if (green >= blue) begin
            a_sel_next = MAX_GREEN;
        end else begin
            a_sel_next = MAX_BLUE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_ready) begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && in_valid) begin
            a_red_reg   <= red;
            a_green_reg <= green;
            a_blue_reg  <= blue;
            a_max_reg   <= a_max_next;
            a_min_reg   <= a_min_next;
            a_sel_reg   <= a_sel_next;
        end
    end

    // Hue numerator in units of delta: sextant offset plus signed channel difference
    always_comb begin
        delta = a_max_reg - a_min_reg;
        case (a_sel_reg)
            MAX_RED_UP: begin
                base   = '0;
                x_term = NUW'(a_green_reg);
                y_term = NUW'(a_blue_reg);
            end
            MAX_RED_WRAP: begin
                base   = {1'b0, delta, 2'b00} + {2'b00, delta, 1'b0};
                x_term = NUW'(a_green_reg);
                y_term = NUW'(a_blue_reg);
            end
            MAX_GREEN: begin
                base   = {2'b00, delta, 1'b0};
                x_term = NUW'(a_blue_reg);
                y_term = NUW'(a_red_reg);
            end
            default: begin
                base   = {1'b0, delta, 2'b00};
                x_term = NUW'(a_red_reg);
                y_term = NUW'(a_green_reg);
            end
        endcase
        hue_num = base + x_term - y_term;
        // Dividends: hue scaled by the fraction bits, saturation as full scale times delta
        hue_n   = NW'(hue_num) << HUE_FRACTION_BITS;
        sat_n   = (NW'(delta) << CB) - NW'(delta);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_ready) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    // Split each dividend into the starting remainder and the bits fed one per cell
    always_ff @(posedge aclk) begin
        if (b_ready && a_valid_reg) begin
            b_rem_reg[RTH_LANE_HUE] <= hue_n[NW-1:QUO_BITS];
            b_dvd_reg[RTH_LANE_HUE] <= hue_n[QUO_BITS-1:0];
            b_dvr_reg[RTH_LANE_HUE] <= delta;
            b_rem_reg[RTH_LANE_SAT] <= sat_n[NW-1:QUO_BITS];
            b_dvd_reg[RTH_LANE_SAT] <= sat_n[QUO_BITS-1:0];
            b_dvr_reg[RTH_LANE_SAT] <= a_max_reg;
            b_side_reg[RTH_SIDE_HUE_ZERO] <= (delta == '0);
            b_side_reg[RTH_SIDE_SAT_ZERO] <= (a_max_reg == '0);
            b_side_reg[CB+RTH_SIDE_FLAGS-1:RTH_SIDE_FLAGS] <= a_max_reg;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_rem   = b_rem_reg;
    assign out_dvr   = b_dvr_reg;
    assign out_dvd   = b_dvd_reg;
    assign out_side  = b_side_reg;

endmodule

// ===== hdl/rth_div_cell.sv =====
// One cell of the divider row: a restoring step per lane, one quotient bit each.
`timescale 1ns / 1ps

module rth_div_cell #(
    parameter int CHANNEL_BITS = rth_pkg::RTH_CHANNEL_BITS,
    parameter int QUO_BITS     = rth_pkg::RTH_HUE_FRAC_BITS + 3,
    parameter int SIDE_BITS    = rth_pkg::RTH_CHANNEL_BITS + rth_pkg::RTH_SIDE_FLAGS,
    parameter int LANES        = rth_pkg::RTH_LANES
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [LANES-1:0][CHANNEL_BITS-1:0]  in_rem,
    input  logic [LANES-1:0][CHANNEL_BITS-1:0]  in_dvr,
    input  logic [LANES-1:0][QUO_BITS-1:0]      in_dvd,
    input  logic [LANES-1:0][QUO_BITS-1:0]      in_quo,
    input  logic [SIDE_BITS-1:0]                in_side,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [LANES-1:0][CHANNEL_BITS-1:0]  out_rem,
    output logic [LANES-1:0][CHANNEL_BITS-1:0]  out_dvr,
    output logic [LANES-1:0][QUO_BITS-1:0]      out_dvd,
    output logic [LANES-1:0][QUO_BITS-1:0]      out_quo,
    output logic [SIDE_BITS-1:0]                out_side
);

    logic                                valid_reg;
    logic [LANES-1:0][CHANNEL_BITS-1:0]  rem_reg, dvr_reg;
    logic [LANES-1:0][QUO_BITS-1:0]      dvd_reg, quo_reg;
    logic [SIDE_BITS-1:0]                side_reg;

    logic [LANES-1:0][CHANNEL_BITS-1:0]  rem_next;
    logic [LANES-1:0][QUO_BITS-1:0]      dvd_next, quo_next;
    logic [LANES-1:0][CHANNEL_BITS:0]    trial, diff;
    logic [LANES-1:0]                    fits;

    assign in_ready = !valid_reg || out_ready;

    // Shift in the next dividend bit, subtract the divisor where it fits
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            trial[i]    = {in_rem[i], in_dvd[i][QUO_BITS-1]};
            diff[i]     = trial[i] - {1'b0, in_dvr[i]};
            fits[i]     = (trial[i] >= {1'b0, in_dvr[i]});
            rem_next[i] = fits[i] ? diff[i][CHANNEL_BITS-1:0] : trial[i][CHANNEL_BITS-1:0];
            dvd_next[i] = {in_dvd[i][QUO_BITS-2:0], 1'b0};
            quo_next[i] = {in_quo[i][QUO_BITS-2:0], fits[i]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // Advance the beat into this cell
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            rem_reg  <= rem_next;
            dvr_reg  <= in_dvr;
            dvd_reg  <= dvd_next;
            quo_reg  <= quo_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_dvr   = dvr_reg;
    assign out_dvd   = dvd_reg;
    assign out_quo   = quo_reg;
    assign out_side  = side_reg;

endmodule

// ===== hdl/rgb_to_hsv.sv =====
// Top level of the RGB to HSV converter: front end, divider row and output register.
`timescale 1ns / 1ps

// Converts one pixel per beat from red, green, blue to hue (sextants with
// HUE_FRACTION_BITS fraction bits, truncated), saturation (delta over maximum,
// truncated) and brightness (largest channel). It takes a new pixel every clock
// while m_tready does not hold the output back; each pixel passes through the
// front end's stage A and stage B registers, the row of divider cells that
// produce one quotient bit each for hue and saturation side by side, and the output register.
// Grey pixels give hue 0, black pixels give saturation and hue 0, and ties for
// the largest channel go to red, then green.
module rgb_to_hsv #(
    parameter int CHANNEL_BITS      = rth_pkg::RTH_CHANNEL_BITS,
    parameter int HUE_FRACTION_BITS = rth_pkg::RTH_HUE_FRAC_BITS
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // red, green, blue from bit 0 up, zero padded to whole bytes
    input  logic [((3*CHANNEL_BITS+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // hue, saturation, brightness from bit 0 up, zero padded to whole bytes
    output logic [((HUE_FRACTION_BITS+3+2*CHANNEL_BITS+7)/8)*8-1:0] m_tdata
);
    import rth_pkg::*;

    localparam int CB   = CHANNEL_BITS;
    localparam int HW   = HUE_FRACTION_BITS + 3;
    localparam int L    = (CB > HW) ? CB : HW;
    localparam int SW   = CB + RTH_SIDE_FLAGS;
    localparam int OW   = HW + 2 * CB;
    localparam int OPAD = ((OW + 7) / 8) * 8;

    // Row links: index 0 is the front end, index k+1 the output of cell k
    logic                              c_valid [L+1];
    logic                              c_ready [L+1];
    logic [RTH_LANES-1:0][CB-1:0]      c_rem   [L+1];
    logic [RTH_LANES-1:0][CB-1:0]      c_dvr   [L+1];
    logic [RTH_LANES-1:0][L-1:0]       c_dvd   [L+1];
    logic [RTH_LANES-1:0][L-1:0]       c_quo   [L+1];
    logic [SW-1:0]                     c_side  [L+1];

    logic            out_valid_reg;
    logic [HW-1:0]   out_hue_reg;
    logic [CB-1:0]   out_sat_reg;
    logic [CB-1:0]   out_bri_reg;
    logic            o_ready;

    logic [HW-1:0]   hue_next;
    logic [CB-1:0]   sat_next;

    rth_front #(
        .CHANNEL_BITS      (CB),
        .HUE_FRACTION_BITS (HUE_FRACTION_BITS),
        .QUO_BITS          (L)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .red       (s_tdata[CB-1:0]),
        .green     (s_tdata[2*CB-1:CB]),
        .blue      (s_tdata[3*CB-1:2*CB]),
        .out_valid (c_valid[0]),
        .out_ready (c_ready[0]),
        .out_rem   (c_rem[0]),
        .out_dvr   (c_dvr[0]),
        .out_dvd   (c_dvd[0]),
        .out_side  (c_side[0])
    );

    assign c_quo[0] = '0;

    // Divider row: one cell per quotient bit
    for (genvar k = 0; k < L; k++) begin : g_cell
        rth_div_cell #(
            .CHANNEL_BITS (CB),
            .QUO_BITS     (L),
            .SIDE_BITS    (SW),
            .LANES        (RTH_LANES)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (c_valid[k]),
            .in_ready  (c_ready[k]),
            .in_rem    (c_rem[k]),
            .in_dvr    (c_dvr[k]),
            .in_dvd    (c_dvd[k]),
            .in_quo    (c_quo[k]),
            .in_side   (c_side[k]),
            .out_valid (c_valid[k+1]),
            .out_ready (c_ready[k+1]),
            .out_rem   (c_rem[k+1]),
            .out_dvr   (c_dvr[k+1]),
            .out_dvd   (c_dvd[k+1]),
            .out_quo   (c_quo[k+1]),
            .out_side  (c_side[k+1])
        );
    end

    // Drop the quotients of grey and black pixels
    always_comb begin
        hue_next = c_side[L][RTH_SIDE_HUE_ZERO] ? '0 : c_quo[L][RTH_LANE_HUE][HW-1:0];
        sat_next = c_side[L][RTH_SIDE_SAT_ZERO] ? '0 : c_quo[L][RTH_LANE_SAT][CB-1:0];
    end

    assign o_ready    = !out_valid_reg || m_tready;
    assign c_ready[L] = o_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (o_ready) begin
            out_valid_reg <= c_valid[L];
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (o_ready && c_valid[L]) begin
            out_hue_reg <= hue_next;
            out_sat_reg <= sat_next;
            out_bri_reg <= c_side[L][SW-1:RTH_SIDE_FLAGS];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OPAD'({out_bri_reg, out_sat_reg, out_hue_reg});

    // Hue stays below six sextants
    a_hue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> ({1'b0, out_hue_reg} < (HW+1)'(6 << HUE_FRACTION_BITS)))
        else $error("hue beyond six sextants");

    // Black pixel gives zero saturation and hue
    a_black: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_bri_reg == '0) |-> (out_sat_reg == '0 && out_hue_reg == '0))
        else $error("black pixel with nonzero saturation or hue");

    // Zero saturation only for grey, so hue must be zero too
    a_grey: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_sat_reg == '0) |-> (out_hue_reg == '0))
        else $error("zero saturation with nonzero hue");

    // Input stalls only while the output register holds a beat
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> out_valid_reg)
        else $error("input stalled with empty output register");

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the RGB to HSV converter: directed table, random pixels, predictor.
`timescale 1ns / 1ps

module tb;

    import rth_pkg::*;

    localparam int CH        = RTH_CHANNEL_BITS;
    localparam int FB        = RTH_HUE_FRAC_BITS;
    localparam int HW        = FB + 3;
    localparam int S_W       = ((3*CH+7)/8)*8;
    localparam int M_W       = ((HW+2*CH+7)/8)*8;
    localparam int CMAX      = (1 << CH) - 1;
    localparam int LATENCY   = 3 + ((CH > HW) ? CH : HW);
    localparam int IDLE_PCT  = 11;
    localparam int RANDOM_PIXELS  = 1550;
    localparam int STEADY_FIRST   = 500;
    localparam int STEADY_LAST    = 800;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int N_ROWS    = 20;

    typedef struct packed {
        logic [HW-1:0] hue;
        logic [CH-1:0] sat;
        logic [CH-1:0] bri;
    } hsv_t;

    typedef struct packed {
        logic [CH-1:0] red;
        logic [CH-1:0] green;
        logic [CH-1:0] blue;
        bit            typed;
        hsv_t          hsv;
    } pixel_row_t;

    // Directed pixels; typed rows carry their result, the rest go through the predictor
    pixel_row_t pixel_table [N_ROWS] = '{
        '{8'd0,   8'd0,   8'd0,   1'b1, '{11'd0,    8'd0,   8'd0}},   // black
        '{8'd255, 8'd255, 8'd255, 1'b1, '{11'd0,    8'd0,   8'd255}}, // white
        '{8'd128, 8'd128, 8'd128, 1'b1, '{11'd0,    8'd0,   8'd128}}, // mid grey
        '{8'd1,   8'd1,   8'd1,   1'b1, '{11'd0,    8'd0,   8'd1}},   // darkest grey
        '{8'd255, 8'd0,   8'd0,   1'b1, '{11'd0,    8'd255, 8'd255}}, // pure red
        '{8'd0,   8'd255, 8'd0,   1'b1, '{11'd512,  8'd255, 8'd255}}, // pure green
        '{8'd0,   8'd0,   8'd255, 1'b1, '{11'd1024, 8'd255, 8'd255}}, // pure blue
        '{8'd255, 8'd255, 8'd0,   1'b1, '{11'd256,  8'd255, 8'd255}}, // red and green tie
        '{8'd0,   8'd255, 8'd255, 1'b1, '{11'd768,  8'd255, 8'd255}}, // green and blue tie
        '{8'd255, 8'd0,   8'd255, 1'b1, '{11'd1280, 8'd255, 8'd255}}, // red and blue tie
        '{8'd255, 8'd0,   8'd1,   1'b0, '0},  // hue just under the wrap
        '{8'd1,   8'd0,   8'd0,   1'b0, '0},  // faintest red
        '{8'd0,   8'd0,   8'd1,   1'b0, '0},
        '{8'd255, 8'd254, 8'd0,   1'b0, '0},
        '{8'd0,   8'd1,   8'd255, 1'b0, '0},
        '{8'd10,  8'd200, 8'd30,  1'b0, '0},
        '{8'd200, 8'd100, 8'd150, 1'b0, '0},
        '{8'd254, 8'd255, 8'd255, 1'b0, '0},
        '{8'd170, 8'd85,  8'd255, 1'b0, '0},
        '{8'd255, 8'd255, 8'd254, 1'b0, '0}
    };

    logic           aclk     = 1'b0;
    logic           aresetn  = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [S_W-1:0] s_tdata  = '0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [M_W-1:0] m_tdata;

    hsv_t hsv_due [$];
    hsv_t got_hsv, want_hsv;
    bit   steady = 1'b0;
    int   mismatches = 0;
    int   results_seen = 0;
    int   pixels_sent = 0;
    int   grey_sent = 0;
    int   ties_sent = 0;
    int   quiet_cycles = 0;

    rgb_to_hsv DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Work out hue, saturation and brightness of one pixel in exact fixed point
    function automatic hsv_t hsv_of(input logic [CH-1:0] r, input logic [CH-1:0] g,
                                    input logic [CH-1:0] b);
        logic [CH-1:0] top, bot;
        logic [31:0]   span, num;
        hsv_t          res;
        top = r;
        if (g > top) top = g;
        if (b > top) top = b;
        bot = r;
        if (g < bot) bot = g;
        if (b < bot) bot = b;
        span = 32'(top) - 32'(bot);
        res.bri = top;
        res.sat = (top != 0) ? CH'((32'(CMAX) * span) / 32'(top)) : '0;
        if (span == 0) begin
            res.hue = '0;
        end else begin
            if (top == r) begin
                if (g >= b) num = 32'(g) - 32'(b);
                else        num = 32'd6 * span - (32'(b) - 32'(g));
            end else if (top == g) begin
                num = (32'd2 * span + 32'(b)) - 32'(r);
            end else begin
                num = (32'd4 * span + 32'(r)) - 32'(g);
            end
            res.hue = HW'((num << FB) / span);
        end
        return res;
    endfunction

    // Present one pixel, hold it until taken, then queue its expected result
    task automatic drive_pixel(input logic [CH-1:0] r, input logic [CH-1:0] g,
                               input logic [CH-1:0] b, input bit typed, input hsv_t given);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_W'({b, g, r});
        do @(posedge aclk); while (!s_tready);
        hsv_due.push_back(typed ? given : hsv_of(r, g, b));
        pixels_sent++;
        if (r == g && g == b) grey_sent++;
        else if ((r == g && r >= b) || (r == b && r >= g) || (g == b && g >= r)) ties_sent++;
    endtask

    // Record a bad result; print only the first few
    function automatic void note_mismatch(input string what, input hsv_t want, input hsv_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: expected hue %0d sat %0d bri %0d, got hue %0d sat %0d bri %0d",
                     $realtime, what, want.hue, want.sat, want.bri, got.hue, got.sat, got.bri);
    endfunction

    // Downstream stalls, none during the steady stretch
    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Compare each result beat with the oldest pixel waiting
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_hsv.hue = m_tdata[HW-1:0];
            got_hsv.sat = m_tdata[HW +: CH];
            got_hsv.bri = m_tdata[HW+CH +: CH];
            results_seen++;
            if (hsv_due.size() == 0) begin
                note_mismatch("result with no pixel pending", '0, got_hsv);
            end else begin
                want_hsv = hsv_due.pop_front();
                if (got_hsv.hue != want_hsv.hue || got_hsv.sat != want_hsv.sat ||
                    got_hsv.bri != want_hsv.bri)
                    note_mismatch("wrong result", want_hsv, got_hsv);
            end
        end
    end

    // Abort when neither side has moved a beat for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat moved in %0d cycles, %0d results pending",
                     WATCHDOG_LIMIT, hsv_due.size());
            $display("tb failed");
            $finish;
        end
    end

    initial begin
        logic [CH-1:0] r, g, b, v, base;
        int            kind;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Walk the directed table
        for (int i = 0; i < N_ROWS; i++)
            drive_pixel(pixel_table[i].red, pixel_table[i].green, pixel_table[i].blue,
                        pixel_table[i].typed, pixel_table[i].hsv);

        // Random pixels, biased towards grey, ties, corners and narrow spans
        for (int n = 0; n < RANDOM_PIXELS; n++) begin
            steady <= (n >= STEADY_FIRST && n < STEADY_LAST);
            kind = $urandom_range(0, 9);
            r = CH'($urandom);
            g = CH'($urandom);
            b = CH'($urandom);
            case (kind)
                0: begin
                    g = r;
                    b = r;
                end
                1: begin
                    v = CH'($urandom_range(1, CMAX));
                    case ($urandom_range(0, 2))
                        0: begin r = v; g = v; b = CH'($urandom_range(0, v)); end
                        1: begin r = v; b = v; g = CH'($urandom_range(0, v)); end
                        default: begin g = v; b = v; r = CH'($urandom_range(0, v)); end
                    endcase
                end
                2: begin
                    if ($urandom_range(0, 2) == 0) r = $urandom_range(0, 1) ? CH'(CMAX) : '0;
                    if ($urandom_range(0, 2) == 0) g = $urandom_range(0, 1) ? CH'(CMAX) : '0;
                    if ($urandom_range(0, 2) == 0) b = $urandom_range(0, 1) ? CH'(CMAX) : '0;
                end
                3: begin
                    base = CH'($urandom_range(0, CMAX - 3));
                    r = base + CH'($urandom_range(0, 3));
                    g = base + CH'($urandom_range(0, 3));
                    b = base + CH'($urandom_range(0, 3));
                end
                default: ;
            endcase
            drive_pixel(r, g, b, 1'b0, '0);
        end
        s_tvalid <= 1'b0;
        steady   <= 1'b0;

        // Drain, then allow the pipeline to settle so stray beats show up
        while (hsv_due.size() != 0) @(posedge aclk);
        repeat (LATENCY + 20) @(posedge aclk);

        $display("converted %0d pixels (%0d grey, %0d with a tied maximum), %0d results checked",
                 pixels_sent, grey_sent, ties_sent, results_seen);
        $display("%0d mismatches", mismatches);
        if (mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/rth_pkg.sv
hdl/rth_front.sv
hdl/rth_div_cell.sv
hdl/rgb_to_hsv.sv
verif/tb.sv
